// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SV39M_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SV39M_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after reset is seen high.
`define SV39M_ASSERT_AFTER_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// ----- rtl/sv39m_pkg.sv -----
// ---------------------------------------------------------------------------
// Sv39 page table mapper package
// Widths, status codes and beat types shared by the mapper and its checker.
// ---------------------------------------------------------------------------
`default_nettype none

package sv39m_pkg;

  localparam int POOL_PAGES_DEF = 16;
  localparam int PAGE_SHIFT     = 12;
  localparam int PTES_PER_PAGE  = 512;
  localparam int IDX_W          = 9;
  localparam int PPN_W          = 44;
  localparam int VA_W           = 39;
  localparam int PA_W           = 56;
  localparam int VPN_W          = VA_W - PAGE_SHIFT;
  localparam int PTE_W          = 64;
  localparam int SIZE_W         = 32;
  localparam int PERM_W         = 8;

  localparam logic [PPN_W-1:0] POOL_BASE_RESET = PPN_W'(64'h80000);

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_MAP    = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [VA_W-1:0]   va;
    logic [SIZE_W-1:0] size_bytes;
    logic [PA_W-1:0]   pa;
    logic [PERM_W-1:0] perm;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [PA_W-1:0]  pte_address;
    logic [PTE_W-1:0] pte_value;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/sv39m_mem.sv -----
// ---------------------------------------------------------------------------
// Sv39 mapper table memory
// PTE store with one write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module sv39m_mem import sv39m_pkg::*; #(
  parameter int DEPTH = POOL_PAGES_DEF * PTES_PER_PAGE,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [PTE_W-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [PTE_W-1:0] rdata
);

  logic [PTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/sv39m_ptrmod.sv -----
// ---------------------------------------------------------------------------
// Sv39 mapper pointer reduction
// Turns a table pointer PPN into a pool page: (ppn - base) mod 2^44 mod pages.
// ---------------------------------------------------------------------------
`default_nettype none

module sv39m_ptrmod import sv39m_pkg::*; #(
  parameter int POOL_PAGES = POOL_PAGES_DEF,
  parameter int PW         = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [PPN_W-1:0] ppn,
  input  wire logic [PPN_W-1:0] base,
  output logic                  done,
  output logic      [PW-1:0]    page
);

  localparam bit POW2 = ((POOL_PAGES & (POOL_PAGES - 1)) == 0);

  generate
    if (POW2) begin : g_mask
      localparam logic [PW-1:0] PAGE_MASK = PW'(POOL_PAGES - 1);
      logic [PPN_W-1:0] rel;
      logic             done_r;

      always_ff @(posedge clk) begin
        if (rst) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          rel <= ppn - base;
        end
      end

      assign done = done_r;
      assign page = rel[PW-1:0] & PAGE_MASK;
    end else begin : g_fold
      // The 44-bit offset is split into four 11-bit chunks, each weighted by
      // 2^(11*i) mod POOL_PAGES, which keeps the sum congruent and below 2^23.
      // A reciprocal multiply then gives a quotient that is low by at most
      // one, so a single conditional subtract finishes the remainder.
      localparam int SUM_W = 23;
      localparam int WT_W  = 10;
      localparam logic [WT_W-1:0]  W1      = WT_W'((64'd1 << 11) % POOL_PAGES);
      localparam logic [WT_W-1:0]  W2      = WT_W'((64'd1 << 22) % POOL_PAGES);
      localparam logic [WT_W-1:0]  W3      = WT_W'((64'd1 << 33) % POOL_PAGES);
      localparam logic [SUM_W-1:0] RECIP   = SUM_W'((64'd1 << SUM_W) / POOL_PAGES);
      localparam logic [SUM_W-1:0] MOD_SUM = SUM_W'(POOL_PAGES);
      localparam logic [PW:0]      MODULUS = (PW+1)'(POOL_PAGES);
      logic [PPN_W-1:0]   rel;
      logic [SUM_W-1:0]   fold;
      logic [SUM_W-1:0]   sum;
      logic [SUM_W-1:0]   sum_d;
      logic [2*SUM_W-1:0] prod;
      logic [SUM_W-1:0]   quo;
      logic [SUM_W-1:0]   back;
      logic [PW:0]        rem_raw;
      logic [PW-1:0]      rem;
      logic [3:0]         vld;
      logic               done_r;

      assign fold = SUM_W'(rel[10:0])
                  + SUM_W'(rel[21:11]) * SUM_W'(W1)
                  + SUM_W'(rel[32:22]) * SUM_W'(W2)
                  + SUM_W'(rel[43:33]) * SUM_W'(W3);
      assign prod = {{SUM_W{1'b0}}, sum} * {{SUM_W{1'b0}}, RECIP};
      assign back = quo * MOD_SUM;

      always_ff @(posedge clk) begin
        if (rst) begin
          vld    <= '0;
          done_r <= 1'b0;
        end else begin
          vld    <= {vld[2:0], start};
          done_r <= vld[3];
        end
        if (start) begin
          rel <= ppn - base;
        end
        if (vld[0]) begin
          sum <= fold;
        end
        if (vld[1]) begin
          quo   <= prod[2*SUM_W-1:SUM_W];
          sum_d <= sum;
        end
        if (vld[2]) begin
          rem_raw <= (PW+1)'(sum_d - back);
        end
        if (vld[3]) begin
          if (rem_raw >= MODULUS) begin
            rem <= PW'(rem_raw - MODULUS);
          end else begin
            rem <= rem_raw[PW-1:0];
          end
        end
      end

      assign done = done_r;
      assign page = rem;
    end
  endgenerate

endmodule

`default_nettype wire

// ----- rtl/sv39_page_table_mapper_top.sv -----
// ---------------------------------------------------------------------------
// Sv39 page table mapper
// Builds and walks a three-level Sv39 page table held in a local page pool.
// ---------------------------------------------------------------------------
// Requests arrive on the in channel (valid/ready) as one beat each: a lookup
// walks the table without allocating, a map writes a leaf for every page of
// the range and allocates missing tables from a bump counter. Each request
// gives exactly one result beat on the out channel (valid/ready).
// One request is handled at a time. Each present upper-level entry passes
// through a table read, a check and a pointer reduction; with a pool size
// that is not a power of two the reduction is a folded reciprocal multiply
// instead of a mask. A table allocation first clears the 512 entries of the
// new page only if that pool page may hold old data, which can happen after
// the pool base (base_ppn) was changed while tables existed.
// After reset the whole store is cleared, one PTE per cycle, while in_ready
// stays low; cfg writes are taken throughout.
// A finished result waits in the output register; the next request may be
// accepted meanwhile, and its result waits until the old beat is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module sv39_page_table_mapper_top import sv39m_pkg::*; #(
  parameter int POOL_PAGES = POOL_PAGES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_t                  out_data,
  input  wire logic             cfg_we,
  input  wire logic [PPN_W-1:0] cfg_wdata
);

  localparam int PW    = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int NW    = $clog2(POOL_PAGES + 1);
  localparam int AW    = PW + IDX_W;
  localparam int DEPTH = POOL_PAGES * PTES_PER_PAGE;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PREP  = 4'd2;
  localparam logic [3:0] S_SPAN  = 4'd3;
  localparam logic [3:0] S_READ  = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_MODW  = 4'd6;
  localparam logic [3:0] S_ZERO  = 4'd7;
  localparam logic [3:0] S_LINK  = 4'd8;
  localparam logic [3:0] S_LEAF  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]        state;
  logic [PPN_W-1:0]  base_ppn;
  logic [NW-1:0]     free_page;
  logic              stray;
  logic [AW-1:0]     clr_addr;
  logic [IDX_W-1:0]  zcnt;
  logic [1:0]        level;
  logic [PW-1:0]     page;
  logic [PW-1:0]     alloc_page;
  logic              kind;
  logic [VA_W-1:0]   va;
  logic [SIZE_W-1:0] size_bytes;
  logic [PERM_W-1:0] perm;
  logic [VPN_W-1:0]  vpn;
  logic [VPN_W-1:0]  remaining;
  logic [PPN_W-1:0]  pa_ppn;
  logic [VA_W-1:0]   end_va;
  out_t              res;

  logic [IDX_W-1:0]  idx;
  logic [AW-1:0]     slot;
  logic [PPN_W-1:0]  page_ppn;
  logic [PPN_W-1:0]  alloc_ppn;
  logic [PA_W-1:0]   slot_addr;
  logic [PTE_W-1:0]  ptr_val;
  logic [PTE_W-1:0]  leaf_val;
  logic [PTE_W-1:0]  rd_data;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [PTE_W-1:0]  mem_wdata;
  logic              mod_start;
  logic              mod_done;
  logic [PW-1:0]     mod_page;
  logic              wr_stray;

  always_comb begin
    case (level)
      2'd2:    idx = vpn[3*IDX_W-1:2*IDX_W];
      2'd1:    idx = vpn[2*IDX_W-1:IDX_W];
      default: idx = vpn[IDX_W-1:0];
    endcase
  end

  assign slot      = {page, idx};
  assign page_ppn  = base_ppn + PPN_W'(page);
  assign alloc_ppn = base_ppn + PPN_W'(alloc_page);
  assign slot_addr = {page_ppn, idx, 3'b000};
  assign ptr_val   = {10'b0, alloc_ppn, 9'b0, 1'b1};
  assign leaf_val  = {10'b0, pa_ppn, 2'b00, perm[PERM_W-1:1], 1'b1};
  assign in_ready  = (state == S_IDLE);

  assign mod_start = (state == S_CHECK) && (level != 2'd0) && rd_data[0];

  // Any write into a page not yet handed out means that page is no longer
  // known to be zero, so later allocations must sweep it.
  assign wr_stray = ((state == S_LINK) || (state == S_LEAF)) && (NW'(page) >= free_page);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = '0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      S_ZERO: begin
        mem_we    = 1'b1;
        mem_waddr = {alloc_page, zcnt};
      end
      S_LINK: begin
        mem_we    = 1'b1;
        mem_wdata = ptr_val;
      end
      S_LEAF: begin
        mem_we    = 1'b1;
        mem_wdata = leaf_val;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  sv39m_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(slot),
    .rdata(rd_data)
  );

  sv39m_ptrmod #(
    .POOL_PAGES(POOL_PAGES),
    .PW        (PW)
  ) u_ptrmod (
    .clk  (clk),
    .rst  (rst),
    .start(mod_start),
    .ppn  (rd_data[PPN_W+9:10]),
    .base (base_ppn),
    .done (mod_done),
    .page (mod_page)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      base_ppn  <= POOL_BASE_RESET;
      free_page <= NW'(1);
      stray     <= 1'b0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_ppn <= cfg_wdata;
      end
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (wr_stray) begin
        stray <= 1'b1;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            kind       <= in_data.kind;
            va         <= in_data.va;
            size_bytes <= in_data.size_bytes;
            perm       <= in_data.perm;
            vpn        <= in_data.va[VA_W-1:PAGE_SHIFT];
            pa_ppn     <= in_data.pa[PA_W-1:PAGE_SHIFT];
            page       <= '0;
            level      <= 2'd2;
            state      <= S_PREP;
          end
        end
        S_PREP: begin
          if (kind == KIND_LOOKUP) begin
            state <= S_READ;
          end else if (size_bytes == '0) begin
            res   <= '{status: ST_ZERO, pte_address: '0, pte_value: '0};
            state <= S_DONE;
          end else begin
            end_va <= va + VA_W'(size_bytes) - VA_W'(1);
            state  <= S_SPAN;
          end
        end
        S_SPAN: begin
          remaining <= end_va[VA_W-1:PAGE_SHIFT] - vpn;
          state     <= S_READ;
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (level == 2'd0) begin
            res   <= '{status: ST_OK, pte_address: slot_addr, pte_value: rd_data};
            state <= S_DONE;
          end else if (rd_data[0]) begin
            state <= S_MODW;
          end else if (kind == KIND_LOOKUP) begin
            res   <= '{status: ST_MISS, pte_address: '0, pte_value: '0};
            state <= S_DONE;
          end else if (free_page >= NW'(POOL_PAGES)) begin
            res   <= '{status: ST_FULL, pte_address: '0, pte_value: '0};
            state <= S_DONE;
          end else begin
            alloc_page <= free_page[PW-1:0];
            free_page  <= free_page + 1'b1;
            zcnt       <= '0;
            state      <= stray ? S_ZERO : S_LINK;
          end
        end
        S_MODW: begin
          if (mod_done) begin
            page  <= mod_page;
            level <= level - 1'b1;
            if ((level == 2'd1) && (kind == KIND_MAP)) begin
              state <= S_LEAF;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_ZERO: begin
          zcnt <= zcnt + 1'b1;
          if (zcnt == IDX_W'(PTES_PER_PAGE - 1)) begin
            state <= S_LINK;
          end
        end
        S_LINK: begin
          page  <= alloc_page;
          level <= level - 1'b1;
          state <= (level == 2'd1) ? S_LEAF : S_READ;
        end
        S_LEAF: begin
          res <= '{status: ST_OK, pte_address: slot_addr, pte_value: leaf_val};
          if (remaining == '0) begin
            state <= S_DONE;
          end else begin
            remaining <= remaining - 1'b1;
            vpn       <= vpn + 1'b1;
            pa_ppn    <= pa_ppn + 1'b1;
            page      <= '0;
            level     <= 2'd2;
            state     <= S_READ;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data <= res;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sv39m_checker.sv -----
// ---------------------------------------------------------------------------
// Sv39 mapper port checker
// Watches the mapper's ports over time and flags illegal behavior.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sv39m_checker import sv39m_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  // A stalled result beat keeps its contents.
  `SV39M_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")

  // Reset leaves no result pending and holds off requests while clearing.
  `SV39M_ASSERT_AFTER_RESET(a_reset_quiet, !out_valid && !in_ready, "block not quiet after reset")

  // Failed requests report a zero address and value.
  `SV39M_ASSERT_NOW(a_err_zero, out_valid && (out_data.status != ST_OK), (out_data.pte_address == '0) && (out_data.pte_value == '0), "error result carries nonzero fields")

  // Only one request is in the walker at a time.
  `SV39M_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request accepted while busy")

endmodule

bind sv39_page_table_mapper_top sv39m_checker u_sv39m_checker (.*);

`default_nettype wire
